// File: rtl/uvs_pkg.sv
// Shared constants and helpers for the UV sphere vertex generator.
// Fixed-point constants of the sine evaluation and configuration register codes.
// No dependencies.
`default_nettype none

package uvs_pkg;

  // default upper bound on ring and segment counts
  localparam int unsigned MAX_SEGMENTS_DEF = 128;

  // configuration reset values
  localparam logic [7:0] RING_COUNT_RST    = 8'd16;
  localparam logic [7:0] SEGMENT_COUNT_RST = 8'd16;

  // smallest usable count
  localparam int unsigned MIN_COUNT = 4;

  // Q30 constants of the quarter-wave sine
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // exact reciprocals for dividing a 32-bit value by a Taylor divisor:
  // m = ceil(2^(32+l) / c), l = ceil(log2 c), quotient = (v * m) >> (32+l)
  localparam logic [32:0] RCP_110 = 33'(((64'd1 << 39) + 64'd109) / 64'd110);
  localparam logic [32:0] RCP_72  = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
  localparam logic [32:0] RCP_42  = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
  localparam logic [32:0] RCP_20  = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
  localparam logic [32:0] RCP_6   = 33'(((64'd1 << 35) + 64'd5) / 64'd6);

  // register indexes (word address bit 2)
  typedef enum logic {
    REG_RING_COUNT    = 1'b0,
    REG_SEGMENT_COUNT = 1'b1
  } cfg_reg_e;

  // side data that travels with a word down the pipeline
  typedef struct packed {
    logic        in_range;
    logic        quad_valid;
    logic [14:0] tl;
    logic [14:0] tr;
    logic [14:0] bl;
    logic [14:0] br;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } side_t;

  // reciprocal of Taylor divisor k (110, 72, 42, 20, 6)
  function automatic logic [32:0] div_rcp(input int unsigned k);
    case (k)
      0: return RCP_110;
      1: return RCP_72;
      2: return RCP_42;
      3: return RCP_20;
      default: return RCP_6;
    endcase
  endfunction

  // matching right shift
  function automatic int unsigned div_shift(input int unsigned k);
    case (k)
      0: return 39;
      1: return 39;
      2: return 38;
      3: return 37;
      default: return 35;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/uvs_divider.sv
// Pipelined rounding divider: floor((num * 2^K + den/2) / den) for num <= den.
// Four long-division stages and one rounding stage. Uses uvs_pkg for nothing.
`default_nettype none

module uvs_divider #(
  parameter int unsigned K  = 32,
  parameter int unsigned CW = 8,
  parameter int unsigned NW = 8
) (
  input  wire logic          clk_i,
  input  wire logic [4:0]    en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [CW-1:0] den_i,
  output logic      [K:0]    quot_o
);

  localparam int unsigned RW   = (CW > NW) ? CW : NW;
  localparam int unsigned QW   = K + 1;
  localparam int unsigned STEP = (K + 3) / 4;

  logic [RW-1:0] rem_q  [4];
  logic [QW-1:0] quot_q [4];
  logic [RW-1:0] den_q  [4];

  logic [RW:0]   r_in [4];
  logic [QW-1:0] q_in [4];
  logic [RW:0]   d_in [4];

  // first stage starts from the integer part, which is 0 or 1
  always_comb begin
    d_in[0] = (RW + 1)'(den_i);
    if ((RW + 1)'(num_i) == d_in[0]) begin
      q_in[0] = QW'(1);
      r_in[0] = '0;
    end else begin
      q_in[0] = '0;
      r_in[0] = (RW + 1)'(num_i);
    end
  end

  for (genvar s = 1; s < 4; s++) begin : g_link
    assign r_in[s] = {1'b0, rem_q[s-1]};
    assign q_in[s] = quot_q[s-1];
    assign d_in[s] = {1'b0, den_q[s-1]};
  end

  // restoring steps, STEP quotient bits per stage
  for (genvar s = 0; s < 4; s++) begin : g_stage
    logic [RW:0]   r_c;
    logic [QW-1:0] q_c;

    always_comb begin
      r_c = r_in[s];
      q_c = q_in[s];
      for (int j = 0; j < STEP; j++) begin
        if (s * STEP + j < K) begin
          r_c = {r_c[RW-1:0], 1'b0};
          if (r_c >= d_in[s]) begin
            r_c = r_c - d_in[s];
            q_c = {q_c[QW-2:0], 1'b1};
          end else begin
            q_c = {q_c[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= r_c[RW-1:0];
        quot_q[s] <= q_c;
        den_q[s]  <= d_in[s][RW-1:0];
      end
    end
  end

  // round to nearest: bump when remainder + den/2 reaches den
  logic [RW:0] rnd_sum;
  assign rnd_sum = {1'b0, rem_q[3]} + {2'b0, den_q[3][RW-1:1]};

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      if (rnd_sum >= {1'b0, den_q[3]}) begin
        quot_o <= quot_q[3] + QW'(1);
      end else begin
        quot_o <= quot_q[3];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/uvs_sine.sv
// Twelve-stage sine magnitude unit: quarter-wave mirror and Taylor series to x^11
// in unsigned Q30. Depends on uvs_pkg for the constants and reciprocals.
`default_nettype none

module uvs_sine (
  input  wire logic        clk_i,
  input  wire logic [11:0] en_i,
  input  wire logic [31:0] phase_i,
  output logic      [30:0] mag_o,
  output logic             neg_o
);

  localparam int unsigned NST = 12;

  logic [65:0] prod_q [NST];
  logic        neg_q  [NST];
  logic [30:0] x_q    [1:10];
  logic [31:0] x2_q   [2:8];

  // stage 0: mirror odd quadrants, scale turns to radians
  logic [30:0] r_c;
  always_comb begin
    r_c = {1'b0, phase_i[29:0]};
    if (phase_i[30]) begin
      r_c = uvs_pkg::Q30_ONE - r_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q[0] <= 66'(62'(r_c) * 62'(uvs_pkg::HALF_PI_Q30));
      neg_q[0]  <= phase_i[31];
    end
  end

  // sign rides along
  for (genvar i = 1; i < NST; i++) begin : g_neg
    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        neg_q[i] <= neg_q[i-1];
      end
    end
  end

  for (genvar i = 1; i < NST; i++) begin : g_stage
    if (i == 1) begin : g_sq
      // x and x*x
      logic [30:0] x_c;
      assign x_c = prod_q[0][60:30];
      always_ff @(posedge clk_i) begin
        if (en_i[i]) begin
          x_q[1]    <= x_c;
          prod_q[1] <= 66'(62'(x_c) * 62'(x_c));
        end
      end
    end else if (i == 2) begin : g_x2
      // x2 and x2 / 110
      logic [31:0] x2_c;
      assign x2_c = prod_q[1][61:30];
      always_ff @(posedge clk_i) begin
        if (en_i[i]) begin
          x_q[2]    <= x_q[1];
          x2_q[2]   <= x2_c;
          prod_q[2] <= 66'(65'(x2_c) * 65'(uvs_pkg::div_rcp(0)));
        end
      end
    end else if (i % 2 == 1) begin : g_term
      // t = 1 - quotient, then multiply by x2 (or by x in the last stage)
      localparam int unsigned KD = (i == 11) ? 4 : (i - 3) / 2;
      localparam int unsigned SH = uvs_pkg::div_shift(KD);
      logic [65:0] q_c;
      logic [30:0] t_c;
      assign q_c = prod_q[i-1] >> SH;
      assign t_c = uvs_pkg::Q30_ONE - q_c[30:0];
      if (i == 11) begin : g_last
        always_ff @(posedge clk_i) begin
          if (en_i[i]) begin
            prod_q[i] <= 66'(62'(x_q[10]) * 62'(t_c));
          end
        end
      end else begin : g_mid
        always_ff @(posedge clk_i) begin
          if (en_i[i]) begin
            prod_q[i] <= 66'(63'(x2_q[i-1]) * 63'(t_c));
            x_q[i]    <= x_q[i-1];
          end
        end
        if (i < 9) begin : g_x2p
          always_ff @(posedge clk_i) begin
            if (en_i[i]) begin
              x2_q[i] <= x2_q[i-1];
            end
          end
        end
      end
    end else begin : g_div
      // divide (x2 * t) >> 30 by the next Taylor divisor
      localparam int unsigned KR = (i - 2) / 2;
      logic [31:0] v_c;
      assign v_c = prod_q[i-1][61:30];
      always_ff @(posedge clk_i) begin
        if (en_i[i]) begin
          prod_q[i] <= 66'(65'(v_c) * 65'(uvs_pkg::div_rcp(KR)));
          x_q[i]    <= x_q[i-1];
        end
      end
      if (i < 9) begin : g_x2p
        always_ff @(posedge clk_i) begin
          if (en_i[i]) begin
            x2_q[i] <= x2_q[i-1];
          end
        end
      end
    end
  end

  assign mag_o = prod_q[NST-1][60:30];
  assign neg_o = neg_q[NST-1];

endmodule

`default_nettype wire

// File: rtl/uv_sphere_vertex_generator_unit.sv
// Top level of the UV sphere vertex generator: config registers, pipeline control,
// output rounding. Depends on uvs_pkg, uvs_divider and uvs_sine.
`default_nettype none

// One grid point (ring, segment) goes in per cycle and one vertex word comes out per
// cycle while the output side does not stall. The pipe has 20 register stages: the
// capture stage, the four-stage rounding dividers for the angles and uv values (plus
// a rounding stage), the twelve-stage Taylor sine units, a product stage and the
// output register. A stall on the output freezes only the full part of the pipe;
// empty stages keep filling, so input is stalled only when all 20 stages hold
// words. Counts below 4 act as 4 and counts above MAX_SEGMENTS act as MAX_SEGMENTS.
module uv_sphere_vertex_generator_unit #(
  parameter int unsigned MAX_SEGMENTS = uvs_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ring_i,
  input  wire logic [7:0]  segment_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             in_range_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic      [16:0] tex_u_o,
  output logic      [16:0] tex_v_o,
  output logic             quad_valid_o,
  output logic      [14:0] corner_tl_o,
  output logic      [14:0] corner_tr_o,
  output logic      [14:0] corner_bl_o,
  output logic      [14:0] corner_br_o
);

  localparam int unsigned CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned EW   = (CW > 8) ? CW : 8;
  localparam int unsigned TW   = 8 + CW + 1;
  localparam int unsigned L    = 20;
  localparam int unsigned DIV0 = 1;
  localparam int unsigned SIN0 = 6;
  localparam int unsigned PRD  = 18;
  localparam int unsigned OUTS = 19;

  // ---------------- config registers ----------------
  logic [7:0] ring_cnt_q, seg_cnt_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_cnt_q <= uvs_pkg::RING_COUNT_RST;
      seg_cnt_q  <= uvs_pkg::SEGMENT_COUNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (uvs_pkg::cfg_reg_e'(paddr[2]))
        uvs_pkg::REG_RING_COUNT:    ring_cnt_q <= pwdata[7:0];
        uvs_pkg::REG_SEGMENT_COUNT: seg_cnt_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (uvs_pkg::cfg_reg_e'(paddr[2]))
      uvs_pkg::REG_RING_COUNT:    prdata = {24'd0, ring_cnt_q};
      uvs_pkg::REG_SEGMENT_COUNT: prdata = {24'd0, seg_cnt_q};
      default:                    prdata = '0;
    endcase
  end

  // clamp a count into [4, MAX_SEGMENTS]
  function automatic logic [CW-1:0] eff_count(input logic [7:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    if (e < EW'(uvs_pkg::MIN_COUNT)) begin
      e = EW'(uvs_pkg::MIN_COUNT);
    end else if (e > EW'(MAX_SEGMENTS)) begin
      e = EW'(MAX_SEGMENTS);
    end
    return CW'(e);
  endfunction

  // ---------------- pipeline control ----------------
  logic [L-1:0] valid_q;
  logic [L-1:0] en;

  // a stage moves when empty or when the next one moves
  always_comb begin
    en[L-1] = !valid_q[L-1] || !out_stall_i;
    for (int i = L - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int i = 1; i < L; i++) begin
        if (en[i]) valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // ---------------- stage 0: capture ----------------
  logic [7:0]    ring_q, seg_q;
  logic [CW-1:0] rings_q, segs_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ring_q  <= ring_i;
      seg_q   <= segment_i;
      rings_q <= eff_count(ring_cnt_q);
      segs_q  <= eff_count(seg_cnt_q);
    end
  end

  // ---------------- stage 1: range flags and corners ----------------
  uvs_pkg::side_t side_q [1:PRD];
  uvs_pkg::side_t side1_c;
  logic [TW-1:0]  tl_c, bl_c;
  logic [EW-1:0]  ring_e, seg_e, rings_e, segs_e;

  always_comb begin
    ring_e  = EW'(ring_q);
    seg_e   = EW'(seg_q);
    rings_e = EW'(rings_q);
    segs_e  = EW'(segs_q);
    tl_c = TW'(ring_q) * (TW'(segs_q) + TW'(1)) + TW'(seg_q);
    bl_c = tl_c + TW'(segs_q) + TW'(1);
    side1_c = '0;
    side1_c.in_range   = (ring_e <= rings_e) && (seg_e <= segs_e);
    side1_c.quad_valid = (ring_e < rings_e) && (seg_e < segs_e);
    if (side1_c.quad_valid) begin
      side1_c.tl = tl_c[14:0];
      side1_c.tr = 15'(tl_c + TW'(1));
      side1_c.bl = bl_c[14:0];
      side1_c.br = 15'(bl_c + TW'(1));
    end
  end

  // ---------------- stages 1..5: angle and uv dividers ----------------
  logic [31:0] phi_quot;
  logic [32:0] theta_quot;
  logic [16:0] texu_quot, texv_quot;

  uvs_divider #(.K(31), .CW(CW), .NW(8)) u_div_phi (
    .clk_i (clk_i),
    .en_i  (en[DIV0+4:DIV0]),
    .num_i (ring_q),
    .den_i (rings_q),
    .quot_o(phi_quot)
  );

  uvs_divider #(.K(32), .CW(CW), .NW(8)) u_div_theta (
    .clk_i (clk_i),
    .en_i  (en[DIV0+4:DIV0]),
    .num_i (seg_q),
    .den_i (segs_q),
    .quot_o(theta_quot)
  );

  uvs_divider #(.K(16), .CW(CW), .NW(8)) u_div_texu (
    .clk_i (clk_i),
    .en_i  (en[DIV0+4:DIV0]),
    .num_i (seg_q),
    .den_i (segs_q),
    .quot_o(texu_quot)
  );

  uvs_divider #(.K(16), .CW(CW), .NW(8)) u_div_texv (
    .clk_i (clk_i),
    .en_i  (en[DIV0+4:DIV0]),
    .num_i (ring_q),
    .den_i (rings_q),
    .quot_o(texv_quot)
  );

  // side data delay line; uv values join at the first sine stage
  uvs_pkg::side_t side_join_c;

  always_comb begin
    side_join_c       = side_q[SIN0-1];
    side_join_c.tex_u = texu_quot;
    side_join_c.tex_v = texv_quot;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) side_q[1] <= side1_c;
    for (int i = 2; i <= PRD; i++) begin
      if (en[i]) side_q[i] <= (i == SIN0) ? side_join_c : side_q[i-1];
    end
  end

  // ---------------- stages 6..17: sine units ----------------
  logic [31:0] phi_ph, theta_ph;
  logic [30:0] sp, cp, st, ct;
  logic        nsp, ncp, nst, nct;

  assign phi_ph   = phi_quot;
  assign theta_ph = theta_quot[31:0];

  uvs_sine u_sin_phi (
    .clk_i  (clk_i),
    .en_i   (en[SIN0+11:SIN0]),
    .phase_i(phi_ph),
    .mag_o  (sp),
    .neg_o  (nsp)
  );

  uvs_sine u_cos_phi (
    .clk_i  (clk_i),
    .en_i   (en[SIN0+11:SIN0]),
    .phase_i(phi_ph + 32'h4000_0000),
    .mag_o  (cp),
    .neg_o  (ncp)
  );

  uvs_sine u_sin_theta (
    .clk_i  (clk_i),
    .en_i   (en[SIN0+11:SIN0]),
    .phase_i(theta_ph),
    .mag_o  (st),
    .neg_o  (nst)
  );

  uvs_sine u_cos_theta (
    .clk_i  (clk_i),
    .en_i   (en[SIN0+11:SIN0]),
    .phase_i(theta_ph + 32'h4000_0000),
    .mag_o  (ct),
    .neg_o  (nct)
  );

  // ---------------- stage 18: products ----------------
  logic [61:0] px_q, pz_q;
  logic [30:0] cp_q;
  logic        nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i) begin
    if (en[PRD]) begin
      px_q <= 62'(sp) * 62'(ct);
      pz_q <= 62'(sp) * 62'(st);
      cp_q <= cp;
      nx_q <= nsp ^ nct;
      ny_q <= ncp;
      nz_q <= nsp ^ nst;
    end
  end

  // ---------------- stage 19: round, saturate, output ----------------
  // saturate to 32767; a zero magnitude is positive
  function automatic logic [15:0] q15_field(input logic neg, input logic [17:0] mag);
    logic [15:0] m;
    m = (mag > 18'd32767) ? 16'd32767 : mag[15:0];
    return (neg && (m != 16'd0)) ? (16'd0 - m) : m;
  endfunction

  logic [62:0] rx_c, rz_c;
  logic [31:0] ry_c;

  assign rx_c = {1'b0, px_q} + (63'd1 << 44);
  assign rz_c = {1'b0, pz_q} + (63'd1 << 44);
  assign ry_c = {1'b0, cp_q} + (32'd1 << 14);

  always_ff @(posedge clk_i) begin
    if (en[OUTS]) begin
      if (side_q[PRD].in_range) begin
        in_range_o   <= 1'b1;
        pos_x_o      <= q15_field(nx_q, rx_c[62:45]);
        pos_y_o      <= q15_field(ny_q, {1'b0, ry_c[31:15]});
        pos_z_o      <= q15_field(nz_q, rz_c[62:45]);
        tex_u_o      <= side_q[PRD].tex_u;
        tex_v_o      <= side_q[PRD].tex_v;
        quad_valid_o <= side_q[PRD].quad_valid;
        corner_tl_o  <= side_q[PRD].tl;
        corner_tr_o  <= side_q[PRD].tr;
        corner_bl_o  <= side_q[PRD].bl;
        corner_br_o  <= side_q[PRD].br;
      end else begin
        in_range_o   <= 1'b0;
        pos_x_o      <= '0;
        pos_y_o      <= '0;
        pos_z_o      <= '0;
        tex_u_o      <= '0;
        tex_v_o      <= '0;
        quad_valid_o <= 1'b0;
        corner_tl_o  <= '0;
        corner_tr_o  <= '0;
        corner_bl_o  <= '0;
        corner_br_o  <= '0;
      end
    end
  end

  assign out_valid_o = valid_q[OUTS];

  // ---------------- assertions ----------------
  // a quad only starts inside the grid
  a_quad_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quad_valid_o |-> in_range_o)
    else $error("quad_valid outside grid");

  // out-of-grid words carry zero positions, uv values and left corners
  a_zero_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> (pos_x_o == 16'sd0) && (pos_y_o == 16'sd0) &&
      (pos_z_o == 16'sd0) && (tex_u_o == 17'd0) && (tex_v_o == 17'd0) &&
      (corner_tl_o == 15'd0) && (corner_bl_o == 15'd0))
    else $error("nonzero fields outside grid");

  // right corners sit one past the left ones
  a_corner_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quad_valid_o |->
      (corner_tr_o == corner_tl_o + 15'd1) && (corner_br_o == corner_bl_o + 15'd1))
    else $error("corner indices inconsistent");

  // input stalls only with every stage occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with a bubble in the pipe");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the UV sphere vertex generator: directed corner points, then
// random grid points over several count settings, checked against a local predictor.
// Depends on uvs_pkg and uv_sphere_vertex_generator_unit.
`default_nettype none

module tb_top;

  localparam int unsigned MAXSEG = 128;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        in_range;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [16:0] u;
    logic [16:0] v;
    logic        quad_valid;
    logic [14:0] tl;
    logic [14:0] tr;
    logic [14:0] bl;
    logic [14:0] br;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] ring_in = '0, seg_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vertex_t got;

  uv_sphere_vertex_generator_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .ring_i(ring_in), .segment_i(seg_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .in_range_o(got.in_range), .pos_x_o(got.px), .pos_y_o(got.py), .pos_z_o(got.pz),
    .tex_u_o(got.u), .tex_v_o(got.v), .quad_valid_o(got.quad_valid),
    .corner_tl_o(got.tl), .corner_tr_o(got.tr), .corner_bl_o(got.bl),
    .corner_br_o(got.br)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the count registers
  logic [7:0] ring_cnt_reg = uvs_pkg::RING_COUNT_RST;
  logic [7:0] seg_cnt_reg  = uvs_pkg::SEGMENT_COUNT_RST;

  vertex_t expected_vertices[$];
  int unsigned mismatches = 0;
  int unsigned vertices_checked = 0;
  int unsigned quads_seen = 0;
  int unsigned idle_cycles = 0;
  bit timed_out = 0;
  bit stall_enable = 1;

  function automatic longint unsigned clamp_count(logic [7:0] c);
    if (c < uvs_pkg::MIN_COUNT) return uvs_pkg::MIN_COUNT;
    if (c > MAXSEG) return MAXSEG;
    return c;
  endfunction

  // |sin(2pi*phase/2^32)| in Q30, mirrored quarter wave, Taylor to x^11
  function automatic longint unsigned sin_q30(logic [31:0] phase, output bit neg);
    longint unsigned r, x, x2, t, s;
    longint unsigned divs[4];
    divs = '{72, 42, 20, 6};
    r = phase[29:0];
    if (phase[30]) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = 64'h4000_0000 - x2 / 110;
    for (int k = 0; k < 4; k++) t = 64'h4000_0000 - ((x2 * t) >> 30) / divs[k];
    s = (x * t) >> 30;
    neg = phase[31] && (s != 0);
    return s;
  endfunction

  function automatic logic [15:0] to_q15(bit neg, longint unsigned mag);
    if (mag > 32767) mag = 32767;
    if (mag == 0) neg = 0;
    return neg ? 16'(17'h10000 - mag) : 16'(mag);
  endfunction

  function automatic vertex_t sphere_vertex(logic [7:0] ring, logic [7:0] seg);
    vertex_t vx;
    longint unsigned rings, segs, r, s, sp, cp, st, ct, tl, bl;
    logic [31:0] phi, theta;
    bit nsp, ncp, nst, nct;
    vx = '0;
    rings = clamp_count(ring_cnt_reg);
    segs = clamp_count(seg_cnt_reg);
    r = ring;
    s = seg;
    if (r > rings || s > segs) return vx;
    phi = 32'(((r << 31) + rings / 2) / rings);
    theta = 32'(((s << 32) + segs / 2) / segs);
    sp = sin_q30(phi, nsp);
    cp = sin_q30(phi + 32'h4000_0000, ncp);
    st = sin_q30(theta, nst);
    ct = sin_q30(theta + 32'h4000_0000, nct);
    vx.in_range = 1;
    vx.px = to_q15(nsp != nct, (sp * ct + (64'd1 << 44)) >> 45);
    vx.py = to_q15(ncp, (cp + (64'd1 << 14)) >> 15);
    vx.pz = to_q15(nsp != nst, (sp * st + (64'd1 << 44)) >> 45);
    vx.u = 17'(((s << 16) + segs / 2) / segs);
    vx.v = 17'(((r << 16) + rings / 2) / rings);
    if (r < rings && s < segs) begin
      tl = r * (segs + 1) + s;
      bl = tl + segs + 1;
      vx.quad_valid = 1;
      vx.tl = 15'(tl);
      vx.tr = 15'(tl + 1);
      vx.bl = 15'(bl);
      vx.br = 15'(bl + 1);
    end
    return vx;
  endfunction

  // random gap: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // output stall pattern and result checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %p", got);
        end else begin
          vertex_t exp_v;
          exp_v = expected_vertices.pop_front();
          vertices_checked++;
          if (exp_v.quad_valid) quads_seen++;
          if (got !== exp_v) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d\n  expected %p\n  actual   %p", mismatches, exp_v, got);
          end
        end
      end
      out_stall <= stall_enable && ($urandom_range(0, 99) < 25);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress");
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // send one grid point, record its prediction on acceptance;
  // valid stays high into the next word unless a gap comes first
  task automatic send_point(logic [7:0] ring, logic [7:0] seg);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    ring_in <= ring;
    seg_in <= seg;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_vertices = {expected_vertices, sphere_vertex(ring, seg)};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write (setup, then access), then read back while the bus is idle
  task automatic write_reg(uvs_pkg::cfg_reg_e idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == uvs_pkg::REG_RING_COUNT) ring_cnt_reg = val[7:0];
    else seg_cnt_reg = val[7:0];
    @(posedge clk);
    if (prdata !== {24'd0, val[7:0]}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back: expected %h actual %h", idx,
                 {24'd0, val[7:0]}, prdata);
    end
  endtask

  task automatic set_counts(logic [7:0] rings, logic [7:0] segs);
    wait_drained();
    write_reg(uvs_pkg::REG_RING_COUNT, {$urandom()} & 32'hFFFF_FF00 | rings);
    write_reg(uvs_pkg::REG_SEGMENT_COUNT, {$urandom()} & 32'hFFFF_FF00 | segs);
  endtask

  // reset counts: poles, seam, out of grid, field extremes
  task automatic test_directed_defaults();
    send_point(0, 0);
    send_point(16, 0);
    send_point(0, 16);
    send_point(16, 16);
    send_point(8, 4);
    send_point(15, 15);
    send_point(17, 3);
    send_point(3, 17);
    send_point(8'hFF, 8'hFF);
    send_point(8'h55, 8'hAA);
    send_point(4, 12);
  endtask

  // count clamping: below minimum and above maximum
  task automatic test_directed_clamp();
    set_counts(8'd0, 8'd255);
    send_point(4, 128);
    send_point(3, 127);
    send_point(5, 0);
    send_point(0, 129);
    set_counts(8'd128, 8'd4);
    send_point(127, 3);
    send_point(128, 4);
    send_point(64, 2);
    send_point(128, 5);
  endtask

  // mostly in-grid points with some out of range
  task automatic test_random(int unsigned n);
    int unsigned rc, sc;
    rc = 32'(clamp_count(ring_cnt_reg));
    sc = 32'(clamp_count(seg_cnt_reg));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8)
        send_point(8'($urandom_range(0, rc)), 8'($urandom_range(0, sc)));
      else
        send_point(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_configs();
    logic [7:0] settings[8][2];
    settings = '{'{4, 4}, '{128, 128}, '{7, 100}, '{3, 200}, '{255, 1},
                 '{33, 17}, '{16, 16}, '{100, 9}};
    foreach (settings[k]) begin
      set_counts(settings[k][0], settings[k][1]);
      if (k == 4) stall_enable = 0;
      if (k == 5) stall_enable = 1;
      test_random(135);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_directed_clamp();
    test_random_configs();
    wait_drained();
    $display("checked %0d vertex words (%0d with quads) over 11 count settings",
             vertices_checked, quads_seen);
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
